// ===== design/pfwv_pkg.sv =====
// Shared types and constants for the priority-flood water volume block.
package pfwv_pkg;

    localparam int SUM_W = 30;
    localparam int CFG_W = 8;
    localparam int IN_W  = 16;
    localparam int CNT_W = 11;

    localparam logic [CFG_W-1:0] SIZE_RESET = 8'd128;
    localparam logic REG_ROWS = 1'b0;
    localparam logic REG_COLS = 1'b1;

    // neighbour steps: down, right, up, left
    localparam logic signed [1:0] ROW_STEP [4] = '{2'sd1, 2'sd0, -2'sd1, 2'sd0};
    localparam logic signed [1:0] COL_STEP [4] = '{2'sd0, 2'sd1, 2'sd0, -2'sd1};

    typedef enum logic [4:0] {
        S_CLEAR,
        S_LOAD,
        S_SEED_RD,
        S_SEED_CHK,
        S_SEED_NEXT,
        S_HEAP_WAIT,
        S_MAIN,
        S_POP_WAIT,
        S_NB,
        S_NB_CHK,
        S_NB_NEXT,
        S_STK,
        S_STK_RD,
        S_STK_CHK,
        S_WIPE,
        S_OUT
    } t_state;

    typedef enum logic [3:0] {
        H_IDLE,
        H_PUSH_CMP,
        H_PUSH_END,
        H_POP_TOP,
        H_POP_LAST,
        H_SIFT,
        H_SIFT_L,
        H_SIFT_R,
        H_SIFT_CMP,
        H_SIFT_END
    } t_heap_state;

    typedef struct packed {
        logic push;
        logic pop;
    } t_heap_ctl;

    typedef struct packed {
        logic busy;
        logic empty;
    } t_heap_sts;

endpackage

// ===== design/priority_flood_water_volume.sv =====
// Height words are loaded in row-major order; after the last word each unvisited border cell is
// seeded into the heap, cells are popped lowest first and their lower neighbours are filled
// to the popped level through a stack, taller ones being pushed back into the heap; then the
// visited marks are wiped before the total is shown.
// Throughput: one grid at a time, set by the heap and the flood sequencer.
// Reset (synchronous, active low) starts a clearing pass of the visited marks during which
// no word is taken; configuration writes still land.
module priority_flood_water_volume import pfwv_pkg::*; #(
    parameter int MAX_ROWS    = 128,
    parameter int MAX_COLS    = 128,
    parameter int HEIGHT_BITS = 16,
    parameter int HEAP_DEPTH  = 16384
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [IN_W-1:0]  i_height,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [SUM_W-1:0] o_water_total,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [2:0]       paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int HW    = (HEIGHT_BITS < IN_W) ? HEIGHT_BITS : IN_W;
    localparam int RB    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CB    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int CELLS = MAX_ROWS * MAX_COLS;
    localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int SIW   = $clog2(CELLS + 1);
    localparam int EW    = HW + RB + CB;
    localparam logic [CNT_W-1:0] ONE_C = CNT_W'(1);
    localparam logic [AW-1:0]    LAST_CELL = AW'(CELLS - 1);
    localparam logic [SIW-1:0]   STK_FULL  = SIW'(CELLS);
    localparam logic [SUM_W:0]   SUM_MAX   = {1'b0, {SUM_W{1'b1}}};

    function automatic logic [AW-1:0] cell_addr(input logic [RB-1:0] r,
                                                input logic [CB-1:0] c);
        return AW'(r) * AW'(MAX_COLS) + AW'(c);
    endfunction

    logic [HW-1:0]    m_height [0:CELLS-1];
    logic             m_vis    [0:CELLS-1];
    logic [RB+CB-1:0] m_stack  [0:CELLS-1];

    t_state r_state, n_state;
    logic [CFG_W-1:0] r_rows_cfg, n_rows_cfg, r_cols_cfg, n_cols_cfg;
    logic [RB-1:0]    r_lr, n_lr, r_cr, n_cr, r_nr, n_nr;
    logic [CB-1:0]    r_lc, n_lc, r_cc, n_cc, r_nc, n_nc;
    logic [AW-1:0]    r_sweep, n_sweep;
    logic             r_sph, n_sph, r_sside, n_sside, r_ret, n_ret;
    logic [CNT_W-1:0] r_si, n_si;
    logic [1:0]       r_nd, n_nd;
    logic [HW-1:0]    r_level, n_level;
    logic [SUM_W-1:0] r_sum, n_sum, r_out, n_out;
    logic [SIW-1:0]   r_top, n_top;

    logic [HW-1:0]    r_hrd;
    logic             r_vrd;
    logic [RB+CB-1:0] r_srd;

    logic [CNT_W-1:0] rows_eff, cols_eff, rows_x, cols_x, nr_x, nc_x;
    logic             cfg_wr, load_acc, load_last, nb_ok, sweep_end;
    logic [RB-1:0]    seed_r;
    logic [CB-1:0]    seed_c;
    logic [AW-1:0]    h_raddr, v_raddr, v_waddr;
    logic             v_we;
    logic [SUM_W:0]   sum_x;
    logic [SIW-1:0]   top_dec;
    logic [AW-1:0]    stk_raddr;
    t_heap_ctl        hctl;
    t_heap_sts        hsts;
    logic [EW-1:0]    hentry, htop;

    assign rows_x   = CNT_W'(r_rows_cfg);
    assign cols_x   = CNT_W'(r_cols_cfg);
    assign rows_eff = (r_rows_cfg == '0) ? ONE_C :
                      (rows_x > CNT_W'(MAX_ROWS)) ? CNT_W'(MAX_ROWS) : rows_x;
    assign cols_eff = (r_cols_cfg == '0) ? ONE_C :
                      (cols_x > CNT_W'(MAX_COLS)) ? CNT_W'(MAX_COLS) : cols_x;

    assign cfg_wr    = psel && penable && pwrite;
    assign load_acc  = i_valid && (r_state == S_LOAD);
    assign load_last = (CNT_W'(r_lr) == rows_eff - ONE_C) && (CNT_W'(r_lc) == cols_eff - ONE_C);
    assign sweep_end = (r_sweep == LAST_CELL);

    // border walk: columns first/last down every row, then top/bottom rows inside
    always_comb begin
        if (!r_sph) begin
            seed_r = r_si[RB-1:0];
            seed_c = r_sside ? CB'(cols_eff - ONE_C) : '0;
        end else begin
            seed_r = r_sside ? RB'(rows_eff - ONE_C) : '0;
            seed_c = r_si[CB-1:0];
        end
    end

    // off-grid steps wrap to a large value and fail the bound test
    assign nr_x  = CNT_W'(r_cr) + {{(CNT_W-2){ROW_STEP[r_nd][1]}}, ROW_STEP[r_nd]};
    assign nc_x  = CNT_W'(r_cc) + {{(CNT_W-2){COL_STEP[r_nd][1]}}, COL_STEP[r_nd]};
    assign nb_ok = (nr_x < rows_eff) && (nc_x < cols_eff);

    assign sum_x = {1'b0, r_sum} + (SUM_W+1)'(r_level - r_hrd);

    assign top_dec   = r_top - SIW'(1);
    assign stk_raddr = top_dec[AW-1:0];

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR:     if (sweep_end) n_state = S_LOAD;
            S_LOAD:      if (load_acc && load_last && !cfg_wr) n_state = S_SEED_RD;
            S_SEED_RD:   n_state = S_SEED_CHK;
            S_SEED_CHK:  n_state = r_vrd ? S_SEED_NEXT : S_HEAP_WAIT;
            S_SEED_NEXT: begin
                n_state = S_SEED_RD;
                if (r_sside) begin
                    if (!r_sph) begin
                        if (r_si == rows_eff - ONE_C && cols_eff <= CNT_W'(2)) n_state = S_MAIN;
                    end else if (r_si == cols_eff - CNT_W'(2)) begin
                        n_state = S_MAIN;
                    end
                end
            end
            S_HEAP_WAIT: if (!hsts.busy) n_state = r_ret ? S_STK : S_SEED_NEXT;
            S_MAIN:      n_state = hsts.empty ? S_WIPE : S_POP_WAIT;
            S_POP_WAIT:  if (!hsts.busy) n_state = S_NB;
            S_NB:        n_state = nb_ok ? S_NB_CHK : S_NB_NEXT;
            S_NB_CHK:    n_state = S_NB_NEXT;
            S_NB_NEXT:   n_state = (r_nd == 2'd3) ? S_STK : S_NB;
            S_STK:       n_state = (r_top == '0) ? S_MAIN : S_STK_RD;
            S_STK_RD:    n_state = S_STK_CHK;
            S_STK_CHK:   n_state = (r_hrd >= r_level) ? S_HEAP_WAIT : S_NB;
            S_WIPE:      if (sweep_end) n_state = S_OUT;
            S_OUT:       if (i_ready) n_state = S_LOAD;
            default:     n_state = S_CLEAR;
        endcase
    end

    always_comb begin
        n_rows_cfg = r_rows_cfg;
        n_cols_cfg = r_cols_cfg;
        n_lr    = r_lr;
        n_lc    = r_lc;
        n_cr    = r_cr;
        n_cc    = r_cc;
        n_nr    = r_nr;
        n_nc    = r_nc;
        n_sweep = r_sweep;
        n_sph   = r_sph;
        n_sside = r_sside;
        n_si    = r_si;
        n_ret   = r_ret;
        n_nd    = r_nd;
        n_level = r_level;
        n_sum   = r_sum;
        n_out   = r_out;
        n_top   = r_top;
        h_raddr = cell_addr(seed_r, seed_c);
        v_raddr = cell_addr(seed_r, seed_c);
        v_we    = 1'b0;
        v_waddr = r_sweep;
        hctl    = '0;
        hentry  = {r_hrd, r_cr, r_cc};
        case (r_state)
            S_CLEAR, S_WIPE: begin
                v_we    = 1'b1;
                n_sweep = sweep_end ? '0 : r_sweep + AW'(1);
                if (sweep_end) n_out = r_sum;
            end
            S_LOAD: begin
                if (load_acc) begin
                    if (load_last) begin
                        n_lr    = '0;
                        n_lc    = '0;
                        n_sph   = 1'b0;
                        n_sside = 1'b0;
                        n_si    = '0;
                    end else if (CNT_W'(r_lc) == cols_eff - ONE_C) begin
                        n_lc = '0;
                        n_lr = r_lr + RB'(1);
                    end else begin
                        n_lc = r_lc + CB'(1);
                    end
                end
            end
            S_SEED_RD: begin
                n_cr = seed_r;
                n_cc = seed_c;
            end
            S_SEED_CHK: begin
                if (!r_vrd) begin
                    v_we      = 1'b1;
                    v_waddr   = cell_addr(r_cr, r_cc);
                    hctl.push = 1'b1;
                    n_ret     = 1'b0;
                end
            end
            S_SEED_NEXT: begin
                if (!r_sside) begin
                    n_sside = 1'b1;
                end else begin
                    n_sside = 1'b0;
                    if (!r_sph && r_si == rows_eff - ONE_C) begin
                        n_sph = 1'b1;
                        n_si  = ONE_C;
                    end else begin
                        n_si = r_si + ONE_C;
                    end
                end
            end
            S_MAIN: begin
                if (!hsts.empty) hctl.pop = 1'b1;
            end
            S_POP_WAIT: begin
                n_level = htop[EW-1 -: HW];
                n_cr    = htop[RB+CB-1:CB];
                n_cc    = htop[CB-1:0];
                n_nd    = '0;
            end
            S_NB: begin
                v_raddr = cell_addr(nr_x[RB-1:0], nc_x[CB-1:0]);
                n_nr    = nr_x[RB-1:0];
                n_nc    = nc_x[CB-1:0];
            end
            S_NB_CHK: begin
                if (!r_vrd) begin
                    v_we    = 1'b1;
                    v_waddr = cell_addr(r_nr, r_nc);
                    if (r_top != STK_FULL) n_top = r_top + SIW'(1);
                end
            end
            S_NB_NEXT: begin
                n_nd = r_nd + 2'd1;
            end
            S_STK: begin
                if (r_top != '0) n_top = r_top - SIW'(1);
            end
            S_STK_RD: begin
                n_cr    = r_srd[RB+CB-1:CB];
                n_cc    = r_srd[CB-1:0];
                h_raddr = cell_addr(r_srd[RB+CB-1:CB], r_srd[CB-1:0]);
            end
            S_STK_CHK: begin
                if (r_hrd >= r_level) begin
                    hctl.push = 1'b1;
                    n_ret     = 1'b1;
                end else begin
                    n_sum = (sum_x > SUM_MAX) ? SUM_MAX[SUM_W-1:0] : sum_x[SUM_W-1:0];
                    n_nd  = '0;
                end
            end
            S_OUT: begin
                if (i_ready) n_sum = '0;
            end
            default: ;
        endcase
        if (cfg_wr) begin
            if (paddr[2] == REG_ROWS) n_rows_cfg = pwdata[CFG_W-1:0];
            if (paddr[2] == REG_COLS) n_cols_cfg = pwdata[CFG_W-1:0];
            n_lr  = '0;
            n_lc  = '0;
            n_sum = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_acc) begin
            m_height[cell_addr(r_lr, r_lc)] <= i_height[HW-1:0];
        end
        r_hrd <= m_height[h_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (v_we) begin
            m_vis[v_waddr] <= (r_state != S_CLEAR) && (r_state != S_WIPE);
        end
        r_vrd <= m_vis[v_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_NB_CHK && !r_vrd && r_top != STK_FULL) begin
            m_stack[r_top[AW-1:0]] <= {r_nr, r_nc};
        end
        r_srd <= m_stack[stk_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_rows_cfg <= SIZE_RESET;
            r_cols_cfg <= SIZE_RESET;
            r_lr       <= '0;
            r_lc       <= '0;
            r_sweep    <= '0;
            r_sum      <= '0;
            r_top      <= '0;
        end else begin
            r_state    <= n_state;
            r_rows_cfg <= n_rows_cfg;
            r_cols_cfg <= n_cols_cfg;
            r_lr       <= n_lr;
            r_lc       <= n_lc;
            r_sweep    <= n_sweep;
            r_sum      <= n_sum;
            r_top      <= n_top;
        end
        r_cr    <= n_cr;
        r_cc    <= n_cc;
        r_nr    <= n_nr;
        r_nc    <= n_nc;
        r_sph   <= n_sph;
        r_sside <= n_sside;
        r_si    <= n_si;
        r_ret   <= n_ret;
        r_nd    <= n_nd;
        r_level <= n_level;
        r_out   <= n_out;
    end

    pfwv_heap #(
        .KW    (HW),
        .EW    (EW),
        .DEPTH (HEAP_DEPTH)
    ) u_heap (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (hctl),
        .i_entry (hentry),
        .o_sts   (hsts),
        .o_top   (htop)
    );

    assign o_ready       = (r_state == S_LOAD);
    assign o_valid       = (r_state == S_OUT);
    assign o_water_total = r_out;
    assign pready        = 1'b1;
    assign prdata        = {24'd0, (paddr[2] == REG_COLS) ? r_cols_cfg : r_rows_cfg};

endmodule

// ===== design/pfwv_heap.sv =====
// Binary min-heap with one read port, one write port and a sift sequencer.
module pfwv_heap import pfwv_pkg::*; #(
    parameter int KW    = 16,
    parameter int EW    = 30,
    parameter int DEPTH = 16384
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_heap_ctl     i_ctl,
    input  logic [EW-1:0] i_entry,
    output t_heap_sts     o_sts,
    output logic [EW-1:0] o_top
);

    localparam int IW = $clog2(DEPTH + 1);
    localparam logic [IW-1:0] FULL = IW'(DEPTH);
    localparam logic [IW-1:0] ONE  = IW'(1);

    logic [EW-1:0] r_mem [0:DEPTH];

    t_heap_state r_state, n_state;
    logic [IW-1:0] r_size, n_size, r_hole, n_hole, r_child, n_child;
    logic [EW-1:0] r_item, n_item, r_last, n_last, r_cent, n_cent, r_top, n_top, r_rd;
    logic [IW-1:0] rd_addr, wa;
    logic [EW-1:0] wd;
    logic          we;
    logic [IW:0]   hole2, size_x;
    logic [IW-1:0] hole_up;
    logic          push_less, right_less, sift_less;

    assign hole2      = {r_hole, 1'b0};
    assign size_x     = {1'b0, r_size};
    assign hole_up    = r_hole >> 1;
    assign push_less  = r_item[EW-1 -: KW] < r_rd[EW-1 -: KW];
    assign right_less = r_rd[EW-1 -: KW] < r_cent[EW-1 -: KW];
    assign sift_less  = r_cent[EW-1 -: KW] < r_last[EW-1 -: KW];

    always_comb begin
        n_state = r_state;
        case (r_state)
            H_IDLE: begin
                if (i_ctl.push && r_size != FULL && r_size != '0) n_state = H_PUSH_CMP;
                else if (i_ctl.pop) n_state = H_POP_TOP;
            end
            H_PUSH_CMP: begin
                if (!push_less) n_state = H_IDLE;
                else if (hole_up > ONE) n_state = H_PUSH_CMP;
                else n_state = H_PUSH_END;
            end
            H_PUSH_END: n_state = H_IDLE;
            H_POP_TOP:  n_state = H_POP_LAST;
            H_POP_LAST: n_state = H_SIFT;
            H_SIFT:     n_state = (hole2 <= size_x) ? H_SIFT_L : H_SIFT_END;
            H_SIFT_L:   n_state = (hole2 != size_x) ? H_SIFT_R : H_SIFT_CMP;
            H_SIFT_R:   n_state = H_SIFT_CMP;
            H_SIFT_CMP: n_state = sift_less ? H_SIFT : H_SIFT_END;
            H_SIFT_END: n_state = H_IDLE;
            default:    n_state = H_IDLE;
        endcase
    end

    always_comb begin
        n_size  = r_size;
        n_hole  = r_hole;
        n_child = r_child;
        n_item  = r_item;
        n_last  = r_last;
        n_cent  = r_cent;
        n_top   = r_top;
        rd_addr = '0;
        we      = 1'b0;
        wa      = '0;
        wd      = r_item;
        case (r_state)
            H_IDLE: begin
                if (i_ctl.push) begin
                    if (r_size != FULL) begin
                        n_size = r_size + ONE;
                        n_hole = r_size + ONE;
                        n_item = i_entry;
                        if (r_size == '0) begin
                            we = 1'b1;
                            wa = ONE;
                            wd = i_entry;
                        end else begin
                            rd_addr = (r_size + ONE) >> 1;
                        end
                    end
                end else if (i_ctl.pop) begin
                    rd_addr = ONE;
                end
            end
            H_PUSH_CMP: begin
                we = 1'b1;
                wa = r_hole;
                if (push_less) begin
                    wd      = r_rd;
                    n_hole  = hole_up;
                    rd_addr = r_hole >> 2;
                end else begin
                    wd = r_item;
                end
            end
            H_PUSH_END: begin
                we = 1'b1;
                wa = r_hole;
                wd = r_item;
            end
            H_POP_TOP: begin
                n_top   = r_rd;
                n_size  = r_size - ONE;
                rd_addr = r_size;
            end
            H_POP_LAST: begin
                n_last = r_rd;
                n_hole = ONE;
            end
            H_SIFT: begin
                rd_addr = hole2[IW-1:0];
            end
            H_SIFT_L: begin
                n_cent  = r_rd;
                n_child = hole2[IW-1:0];
                rd_addr = hole2[IW-1:0] | ONE;
            end
            H_SIFT_R: begin
                if (right_less) begin
                    n_cent  = r_rd;
                    n_child = r_child | ONE;
                end
            end
            H_SIFT_CMP: begin
                if (sift_less) begin
                    we     = 1'b1;
                    wa     = r_hole;
                    wd     = r_cent;
                    n_hole = r_child;
                end
            end
            H_SIFT_END: begin
                if (r_size != '0) begin
                    we = 1'b1;
                    wa = r_hole;
                    wd = r_last;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_rd <= r_mem[rd_addr];
        if (we) begin
            r_mem[wa] <= wd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= H_IDLE;
            r_size  <= '0;
        end else begin
            r_state <= n_state;
            r_size  <= n_size;
        end
        r_hole  <= n_hole;
        r_child <= n_child;
        r_item  <= n_item;
        r_last  <= n_last;
        r_cent  <= n_cent;
        r_top   <= n_top;
    end

    assign o_sts.busy  = (r_state != H_IDLE);
    assign o_sts.empty = (r_size == '0);
    assign o_top       = r_top;

endmodule

// ===== design/pfwv_checker.sv =====
// Port-level checks for the priority-flood water volume block, with bind.
module pfwv_checker import pfwv_pkg::*; (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_valid,
    input logic             o_ready,
    input logic             o_valid,
    input logic             i_ready,
    input logic [SUM_W-1:0] o_water_total,
    input logic             pready
);

    // a pending total blocks new words
    a_no_load_while_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_ready)
        else $error("word taken while total pending");

    a_pready_high: assert property (@(posedge i_clk) pready)
        else $error("pready low");

    a_out_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_water_total))
        else $error("total dropped or changed while stalled");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_ready)
        else $error("activity straight after reset");

    // total only comes out after the block stopped loading
    a_out_after_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(!o_ready))
        else $error("total appeared while loading");

endmodule

bind priority_flood_water_volume pfwv_checker u_pfwv_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_valid       (i_valid),
    .o_ready       (o_ready),
    .o_valid       (o_valid),
    .i_ready       (i_ready),
    .o_water_total (o_water_total),
    .pready        (pready)
);

// ===== tb/pfwv_checker.sv =====
// Checker: watches the height, total and register ports, predicts each grid total and compares.
module pfwv_scoreboard import pfwv_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             in_valid,
    input  logic             in_ready,
    input  logic [IN_W-1:0]  in_height,
    input  logic             out_valid,
    input  logic             out_ready,
    input  logic [SUM_W-1:0] out_total,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [2:0]       paddr,
    input  logic [31:0]      pwdata,
    input  logic             pready,
    output int               fail_count,
    output int               owed_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int GRID_MAX = 128;
    localparam int CELLS    = GRID_MAX * GRID_MAX;
    localparam longint SUM_TOP = (64'd1 << SUM_W) - 1;
    localparam logic [2:0] ADDR_ROWS = {REG_ROWS, 2'b00};
    localparam logic [2:0] ADDR_COLS = {REG_COLS, 2'b00};

    logic [IN_W-1:0]  grid_h [CELLS];
    bit               seen   [CELLS];
    int               pool[$];
    int               pile[$];
    logic [SUM_W-1:0] totals_owed[$];
    logic [CFG_W-1:0] rows_reg = SIZE_RESET;
    logic [CFG_W-1:0] cols_reg = SIZE_RESET;
    int               load_pos = 0;

    initial begin
        fail_count = 0;
        owed_count = 0;
    end

    function automatic int eff_size(logic [CFG_W-1:0] v);
        if (v == 0) return 1;
        if (v > GRID_MAX) return GRID_MAX;
        return int'(v);
    endfunction

    function automatic void mark_border(int pos);
        if (!seen[pos]) begin
            seen[pos] = 1'b1;
            pool.push_back(pos);
        end
    endfunction

    function automatic void spread(int pos, int rows, int cols);
        int r, c, nr, nc, q;
        r = pos / cols;
        c = pos % cols;
        for (int d = 0; d < 4; d++) begin
            nr = r + int'(ROW_STEP[d]);
            nc = c + int'(COL_STEP[d]);
            if (nr >= 0 && nc >= 0 && nr < rows && nc < cols) begin
                q = nr * cols + nc;
                if (!seen[q]) begin
                    seen[q] = 1'b1;
                    pile.push_back(q);
                end
            end
        end
    endfunction

    // lowest cell first; a linear search is plenty for the grid sizes used here
    function automatic logic [SUM_W-1:0] flood_volume(int rows, int cols);
        longint vol;
        int best, pos, q;
        logic [IN_W-1:0] level;
        vol = 0;
        for (int i = 0; i < CELLS; i++) seen[i] = 1'b0;
        pool.delete();
        pile.delete();
        for (int i = 0; i < rows; i++) begin
            mark_border(i * cols);
            mark_border(i * cols + cols - 1);
        end
        for (int j = 1; j + 1 < cols; j++) begin
            mark_border(j);
            mark_border((rows - 1) * cols + j);
        end
        while (pool.size() > 0) begin
            best = 0;
            for (int k = 1; k < pool.size(); k++)
                if (grid_h[pool[k]] < grid_h[pool[best]]) best = k;
            pos = pool[best];
            pool.delete(best);
            level = grid_h[pos];
            spread(pos, rows, cols);
            while (pile.size() > 0) begin
                q = pile.pop_back();
                if (grid_h[q] >= level) begin
                    pool.push_back(q);
                end else begin
                    vol += level - grid_h[q];
                    if (vol > SUM_TOP) vol = SUM_TOP;
                    spread(q, rows, cols);
                end
            end
        end
        return vol[SUM_W-1:0];
    endfunction

    function automatic void note_fail(string what, longint want, longint got);
        if (fail_count < 10)
            $display("mismatch %0s: expected %0d, got %0d", what, want, got);
        fail_count++;
    endfunction

    always @(posedge i_clk) begin : watch
        int total;
        logic [SUM_W-1:0] want;
        if (!i_rst_n) begin
            rows_reg = SIZE_RESET;
            cols_reg = SIZE_RESET;
            load_pos = 0;
        end else begin
            if (psel && penable && pwrite && pready &&
                (paddr == ADDR_ROWS || paddr == ADDR_COLS)) begin
                if (paddr == ADDR_ROWS) rows_reg = pwdata[CFG_W-1:0];
                else cols_reg = pwdata[CFG_W-1:0];
                load_pos = 0;
            end
            if (in_valid && in_ready) begin
                total = eff_size(rows_reg) * eff_size(cols_reg);
                if (load_pos >= total) load_pos = 0;
                grid_h[load_pos] = in_height;
                load_pos++;
                if (load_pos >= total) begin
                    totals_owed.push_back(flood_volume(eff_size(rows_reg), eff_size(cols_reg)));
                    load_pos = 0;
                end
            end
            if (out_valid && out_ready) begin
                if (totals_owed.size() == 0) begin
                    note_fail("unexpected total word", -1, out_total);
                end else begin
                    want = totals_owed.pop_front();
                    if (out_total !== want) note_fail("water_total", want, out_total);
                end
            end
        end
        owed_count <= totals_owed.size();
    end
endmodule

// ===== tb/testbench.sv =====
// Testbench top: clock, reset, height and register stimulus, receiver stalls and verdict.
module testbench import pfwv_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint CYCLE_LIMIT = 6_000_000;
    localparam int     WORDS_WANTED = 1750;
    localparam logic [2:0] ADDR_ROWS = {REG_ROWS, 2'b00};
    localparam logic [2:0] ADDR_COLS = {REG_COLS, 2'b00};

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_valid = 1'b0;
    logic             o_ready;
    logic [IN_W-1:0]  i_height = '0;
    logic             o_valid;
    logic             i_ready = 1'b0;
    logic [SUM_W-1:0] o_water_total;
    logic             psel = 1'b0;
    logic             penable = 1'b0;
    logic             pwrite = 1'b0;
    logic [2:0]       paddr = '0;
    logic [31:0]      pwdata = '0;
    logic [31:0]      prdata;
    logic             pready;

    int     fail_count;
    int     owed_count;
    bit     quiet = 1'b0;      // no idling on either side while set
    bit     want_hold = 1'b0;
    bit     held = 1'b0;
    int     hold_left = 0;
    int     words_sent = 0;
    longint cycles = 0;

    always #4 i_clk = ~i_clk;

    priority_flood_water_volume dut (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_height,
        .o_valid, .i_ready, .o_water_total,
        .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
    );

    pfwv_scoreboard checker_i (
        .i_clk, .i_rst_n,
        .in_valid(i_valid), .in_ready(o_ready), .in_height(i_height),
        .out_valid(o_valid), .out_ready(i_ready), .out_total(o_water_total),
        .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
        .fail_count, .owed_count
    );

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // receiver: random stalls, plus one long hold-off once a total is waiting
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_ready <= 1'b0;
        end else if (want_hold && !held && o_valid) begin
            held <= 1'b1;
            hold_left <= 2000;
            i_ready <= 1'b0;
        end else begin
            i_ready <= quiet || ($urandom_range(99) >= 32);
        end
    end

    task automatic reg_write(logic [2:0] addr, logic [31:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic send_word(logic [IN_W-1:0] h);
        bit took;
        while (!quiet && $urandom_range(99) < 32) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_height <= h;
        do begin
            @(negedge i_clk);
            took = o_ready;
            @(posedge i_clk);
        end while (!took);
        words_sent++;
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (owed_count > 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
    endtask

    task automatic set_size(logic [31:0] rows, logic [31:0] cols);
        reg_write(ADDR_ROWS, rows);
        reg_write(ADDR_COLS, cols);
    endtask

    // spread: 0 small heights (lots of pooling), 1 full range, 2 bowl
    task automatic send_grid(int rows, int cols, int spread);
        logic [IN_W-1:0] h;
        for (int r = 0; r < rows; r++)
            for (int c = 0; c < cols; c++) begin
                case (spread)
                    0: h = IN_W'($urandom_range(15));
                    1: h = IN_W'($urandom_range(16'hFFFF));
                    default: h = (r == 0 || c == 0 || r == rows - 1 || c == cols - 1) ?
                                 IN_W'(16'd40000 + $urandom_range(25535)) :
                                 IN_W'($urandom_range(40000));
                endcase
                send_word(h);
            end
    endtask

    initial begin : stimulus
        int rows, cols, grids;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // zero sizes act as one: single cell, nothing held
        set_size(0, 0);
        send_word(16'hFFFF);
        wait_drained();

        // walled 3x3 with a pit at the centre
        set_size(3, 3);
        for (int k = 0; k < 9; k++) send_word(k == 4 ? 16'h0000 : 16'hFFFF);
        wait_drained();
        set_size(3, 3);
        for (int k = 0; k < 9; k++) send_word(k == 4 ? 16'hFFFE : 16'hFFFF);
        wait_drained();

        // a write mid-grid restarts loading
        set_size(2, 2);
        send_word(16'h5555);
        send_word(16'hAAAA);
        i_valid <= 1'b0;
        repeat (50) @(posedge i_clk);
        set_size(2, 3);
        for (int k = 0; k < 6; k++) send_word(IN_W'(16'h1234 + k));
        wait_drained();

        // size extremes: oversize clamps, thin grids
        set_size(255, 1);
        send_grid(128, 1, 1);
        wait_drained();
        set_size(1, 200);
        send_grid(1, 128, 0);
        wait_drained();
        set_size(128, 3);
        send_grid(128, 3, 2);
        wait_drained();

        grids = 0;
        while (words_sent < WORDS_WANTED) begin
            quiet = (grids >= 10 && grids < 16);
            rows = $urandom_range(9, 3);
            cols = $urandom_range(9, 3);
            if ($urandom_range(9) == 0) rows = $urandom_range(2, 1);
            set_size(rows, cols);
            send_grid(rows, cols, $urandom_range(2));
            // two grids back to back; the receiver holds off on the first total
            // while the second grid is still being offered
            if (grids == 3) begin
                want_hold = 1'b1;
                send_grid(rows, cols, 0);
            end
            wait_drained();
            grids++;
        end
        quiet = 1'b0;

        i_valid <= 1'b0;
        @(posedge i_clk);
        while (owed_count > 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule
